// ----- rtl/mtt_pkg.sv -----
// Types and constants shared by the marker track table and its entry cells.
// No dependencies.
`default_nettype none

package mtt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ID_BITS     = 10;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MISS_W      = 8;

    localparam logic [MISS_W-1:0] COUNT_MAX        = 8'hFF;
    localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = 8'd10;

    localparam logic OP_DETECT    = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    typedef enum logic [2:0] {
        KIND_KNOWN   = 3'd0,
        KIND_ADDED   = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_EVICTED = 3'd3,
        KIND_DONE    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_AGE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic               operation;
        logic [ID_BITS-1:0] marker_id;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   slot;
        logic [ID_BITS-1:0] marker_id_out;
        logic [CNT_W-1:0]   entry_count;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [MISS_W-1:0]  count;
        logic               seen;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic write;
        logic hit;
        logic age;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/mtt_cell.sv -----
// One table entry: identifier, miss count and seen flag, loadable from its right-hand neighbour.
// Depends on mtt_pkg.
`default_nettype none

module mtt_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mtt_pkg::t_cell_ctl          i_ctl,
    input  wire logic [mtt_pkg::ID_BITS-1:0] i_new_id,
    input  wire mtt_pkg::t_entry             i_next,
    output mtt_pkg::t_entry                  o_entry
);

    logic [mtt_pkg::ID_BITS-1:0] r_id;
    logic [mtt_pkg::MISS_W-1:0]  r_count;
    logic                        r_seen;
    logic [mtt_pkg::ID_BITS-1:0] n_id;
    logic [mtt_pkg::MISS_W-1:0]  n_count;
    logic                        n_seen;

    always_comb begin
        n_id    = r_id;
        n_count = r_count;
        n_seen  = r_seen;
        priority if (i_ctl.shift) begin
            n_id    = i_next.id;
            n_count = i_next.count;
            n_seen  = i_next.seen;
        end else if (i_ctl.write) begin
            n_id    = i_new_id;
            n_count = '0;
            n_seen  = 1'b1;
        end else if (i_ctl.hit) begin
            n_count = '0;
            n_seen  = 1'b1;
        end else if (i_ctl.age) begin
            if (!r_seen && (r_count != mtt_pkg::COUNT_MAX)) begin
                n_count = r_count + 1'b1;
            end
            n_seen = 1'b0;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_count <= n_count;
    end

    assign o_entry = '{id: r_id, count: r_count, seen: r_seen};

endmodule

`default_nettype wire

// ----- rtl/marker_track_table.sv -----
// Top level of the marker track table: control sequencer and the row of entry cells.
// Depends on mtt_pkg and mtt_cell.
`default_nettype none

// A detection is registered on transfer, then compared in parallel across all cells, and its
// result is registered; busy is high for one cycle. An end of frame keeps busy high while
// every cell is aged, then while the walk visits each valid entry (evicting it and shifting
// the cells above it down by one, or stepping past it), and while a final step reports the summary.
// Each result is shown for exactly one cycle on o_strobe and cannot be held off by the
// receiver. miss_limit may be written only while busy is low and no result is pending.
module marker_track_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire mtt_pkg::t_item              i_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [mtt_pkg::MISS_W-1:0]  i_cfg_data,
    output logic                             o_strobe,
    output mtt_pkg::t_result                 o_result
);

    localparam int DEPTH = mtt_pkg::TABLE_DEPTH;
    localparam int IDX_W = mtt_pkg::IDX_W;
    localparam int CNT_W = mtt_pkg::CNT_W;

    mtt_pkg::t_state              r_state;
    mtt_pkg::t_state              n_state;
    logic [mtt_pkg::ID_BITS-1:0]  r_id;
    logic [CNT_W-1:0]             r_occ;
    logic [CNT_W-1:0]             n_occ;
    logic [CNT_W-1:0]             r_pos;
    logic [CNT_W-1:0]             n_pos;
    logic [mtt_pkg::MISS_W-1:0]   r_limit;
    logic                         r_strobe;
    logic                         n_strobe;
    mtt_pkg::t_result             r_res;
    mtt_pkg::t_result             n_res;

    mtt_pkg::t_entry              cell_q [DEPTH];
    mtt_pkg::t_cell_ctl           cell_ctl [DEPTH];
    logic                         hit_any;
    logic [IDX_W-1:0]             hit_idx;
    mtt_pkg::t_entry              sel;
    logic                         walk_end;
    logic                         evict;
    logic                         accept;

    assign accept = start && !busy;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            mtt_pkg::t_entry next_entry;
            if (g < DEPTH - 1) begin : g_mid
                assign next_entry = cell_q[g+1];
            end else begin : g_end
                assign next_entry = cell_q[g];
            end
            mtt_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (cell_ctl[g]),
                .i_new_id (r_id),
                .i_next   (next_entry),
                .o_entry  (cell_q[g])
            );
        end
    endgenerate

    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if ((CNT_W'(k) < r_occ) && (cell_q[k].id == r_id)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    assign sel      = cell_q[r_pos[IDX_W-1:0]];
    assign walk_end = (r_pos == r_occ);
    assign evict    = sel.count > r_limit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.operation == mtt_pkg::OP_DETECT) ?
                              mtt_pkg::ST_LOOKUP : mtt_pkg::ST_AGE;
                end
            end
            mtt_pkg::ST_LOOKUP: n_state = mtt_pkg::ST_IDLE;
            mtt_pkg::ST_AGE:    n_state = mtt_pkg::ST_WALK;
            mtt_pkg::ST_WALK: begin
                if (walk_end) begin
                    n_state = mtt_pkg::ST_IDLE;
                end
            end
            default: n_state = mtt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_occ    = r_occ;
        n_pos    = r_pos;
        n_strobe = 1'b0;
        n_res    = '{kind: mtt_pkg::KIND_DONE, slot: '0, marker_id_out: '0,
                     entry_count: r_occ, last: 1'b1};
        for (int k = 0; k < DEPTH; k++) begin
            cell_ctl[k] = '0;
        end
        unique case (r_state)
            mtt_pkg::ST_IDLE: begin
            end
            mtt_pkg::ST_LOOKUP: begin
                n_strobe            = 1'b1;
                n_res.marker_id_out = r_id;
                if (hit_any) begin
                    cell_ctl[hit_idx].hit = 1'b1;
                    n_res.kind            = mtt_pkg::KIND_KNOWN;
                    n_res.slot            = hit_idx;
                end else if (r_occ < CNT_W'(DEPTH)) begin
                    cell_ctl[r_occ[IDX_W-1:0]].write = 1'b1;
                    n_occ             = r_occ + 1'b1;
                    n_res.kind        = mtt_pkg::KIND_ADDED;
                    n_res.slot        = r_occ[IDX_W-1:0];
                    n_res.entry_count = r_occ + 1'b1;
                end else begin
                    n_res.kind = mtt_pkg::KIND_DROPPED;
                end
            end
            mtt_pkg::ST_AGE: begin
                for (int k = 0; k < DEPTH; k++) begin
                    cell_ctl[k].age = 1'b1;
                end
                n_pos = '0;
            end
            mtt_pkg::ST_WALK: begin
                n_strobe = walk_end || evict;
                if (!walk_end) begin
                    if (evict) begin
                        for (int k = 0; k < DEPTH; k++) begin
                            cell_ctl[k].shift = (CNT_W'(k) >= r_pos);
                        end
                        n_occ = r_occ - 1'b1;
                        n_res = '{kind: mtt_pkg::KIND_EVICTED, slot: r_pos[IDX_W-1:0],
                                  marker_id_out: sel.id, entry_count: r_occ - 1'b1,
                                  last: 1'b0};
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mtt_pkg::ST_IDLE;
            r_occ    <= '0;
            r_pos    <= '0;
            r_limit  <= mtt_pkg::MISS_LIMIT_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_pos    <= n_pos;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_id <= i_item.marker_id;
        end
    end

    assign busy     = (r_state != mtt_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("occupancy beyond table depth");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtt_pkg::ST_WALK) |-> (r_pos <= r_occ))
        else $error("walk position passed occupancy");

    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.kind == mtt_pkg::KIND_EVICTED)) |-> !o_result.last)
        else $error("eviction marked as final result");

    a_detect_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtt_pkg::ST_LOOKUP) |=> (o_strobe && o_result.last && !busy))
        else $error("detection did not give exactly one final result");

    a_evict_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mtt_pkg::ST_WALK) && !walk_end && evict) |=> (r_occ == $past(r_occ) - 1'b1))
        else $error("eviction did not reduce occupancy");

endmodule

`default_nettype wire
